@@ sv/weighted_polar_vector_mean_defines.svh @@
// Assertion macros shared by the weighted polar vector mean RTL.
`ifndef WEIGHTED_POLAR_VECTOR_MEAN_DEFINES_SVH
`define WEIGHTED_POLAR_VECTOR_MEAN_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WPVM_ASSERT_HOLDS(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("weighted_polar_vector_mean: assertion failed");
// Next-cycle implication.
`define WPVM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("weighted_polar_vector_mean: assertion failed");
`else
`define WPVM_ASSERT_HOLDS(lbl, ck, rn, ante, cons)
`define WPVM_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ sv/wpvm_pkg.sv @@
// Types, constants and the arctangent table for the weighted polar vector mean.
`timescale 1ns / 1ps
`default_nettype none
package wpvm_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W = 5;
	localparam logic signed [32:0] GAIN_INV = 33'sd652032874;

	localparam logic [15:0] DEG_TURN = 16'd36000;
	localparam logic [16:0] TWO_TURN = 17'd72000;
	localparam logic [31:0] RND_BIAS = 32'd18000;
	// floor(2^48 / 36000): degrees to binary angle by reciprocal multiply
	localparam logic [32:0] RECIP_TURN = 33'd7818749353;
	localparam int SCALE_STEPS = 3;

	localparam int PROD_W = 48;
	localparam int SUM_W = 58;
	localparam int WTOT_W = 26;
	localparam int MEAN_W = 31;
	localparam int SEQ_W = $clog2(SUM_W);
	localparam int ROOT_STEPS = 32;
	localparam int RAD_W = 64;
	localparam int VEC_W = 36;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [15:0] speed;
		logic [15:0] direction;
		logic [15:0] weight;
		logic        last;
	} wpvm_in_t;

	typedef struct packed {
		logic [15:0] mean_speed;
		logic [15:0] mean_direction;
		logic        weight_zero;
	} wpvm_out_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] east_prod;
		logic signed [PROD_W-1:0] north_prod;
		logic [15:0]              weight;
		logic                     last;
	} wpvm_entry_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIV,
		F_ROT,
		F_MAP,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_ACC,
		B_CHECK,
		B_DIV,
		B_SQR,
		B_SUM,
		B_ROOT,
		B_VEC,
		B_SCALE,
		B_FIN
	} back_state_t;

	// atan(2^-i) as a 32 bit binary angle
	function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
		unique case (i)
			5'd0:  atan_bam = 32'd536870912;
			5'd1:  atan_bam = 32'd316933406;
			5'd2:  atan_bam = 32'd167458907;
			5'd3:  atan_bam = 32'd85004756;
			5'd4:  atan_bam = 32'd42667331;
			5'd5:  atan_bam = 32'd21354465;
			5'd6:  atan_bam = 32'd10679838;
			5'd7:  atan_bam = 32'd5340245;
			5'd8:  atan_bam = 32'd2670163;
			5'd9:  atan_bam = 32'd1335087;
			5'd10: atan_bam = 32'd667544;
			5'd11: atan_bam = 32'd333772;
			5'd12: atan_bam = 32'd166886;
			5'd13: atan_bam = 32'd83443;
			5'd14: atan_bam = 32'd41722;
			5'd15: atan_bam = 32'd20861;
			5'd16: atan_bam = 32'd10430;
			5'd17: atan_bam = 32'd5215;
			5'd18: atan_bam = 32'd2608;
			5'd19: atan_bam = 32'd1304;
			5'd20: atan_bam = 32'd652;
			5'd21: atan_bam = 32'd326;
			5'd22: atan_bam = 32'd163;
			5'd23: atan_bam = 32'd81;
			5'd24: atan_bam = 32'd41;
			5'd25: atan_bam = 32'd20;
			5'd26: atan_bam = 32'd10;
			5'd27: atan_bam = 32'd5;
			5'd28: atan_bam = 32'd3;
			5'd29: atan_bam = 32'd1;
			default: atan_bam = 32'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ sv/wpvm_front.sv @@
// Front end: accept a word, form its unit vector and weighted east/north products.
`timescale 1ns / 1ps
`default_nettype none
module wpvm_front import wpvm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  wpvm_in_t    item,
	output logic        push,
	output wpvm_entry_t entry,
	input  logic        full
);

	front_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	logic [15:0] deg_q;
	logic [31:0] q0_q;
	logic [16:0] rm_q;
	logic [1:0] quad_q;
	logic [31:0] sw_q;
	logic [15:0] weight_q;
	logic last_q;
	logic signed [32:0] rx_q, ry_q, rz_q;
	logic signed [15:0] ue_q, un_q;
	logic signed [PROD_W-1:0] pe_q, pn_q;

	logic [15:0] dir_mod;
	logic rm_ge1, rm_ge2;
	logic [31:0] bam_fix;
	logic signed [32:0] rdx, rdy, atan_s;
	logic signed [15:0] cos_v, sin_v, ue_d, un_d;
	logic signed [PROD_W-1:0] sw_ext, ue_ext, un_ext;
	logic div_last, rot_last;

	function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] r;
		t = 34'(v) + 34'sd16384;
		r = 19'(t >>> 15);
		if (r > 19'sd32767)
			to_q15 = 16'sd32767;
		else if (r < -19'sd32767)
			to_q15 = -16'sd32767;
		else
			to_q15 = 16'(r);
	endfunction

	assign dir_mod = (item.direction >= DEG_TURN) ? item.direction - DEG_TURN : item.direction;

	// reciprocal estimate is at most two short of the rounded quotient; the remainder fixes it
	assign rm_ge1 = rm_q >= {1'b0, DEG_TURN};
	assign rm_ge2 = rm_q >= TWO_TURN;
	assign bam_fix = q0_q + {30'b0, rm_ge2, rm_ge1 & !rm_ge2};

	assign rdx = ry_q >>> step_q;
	assign rdy = rx_q >>> step_q;
	assign atan_s = $signed({1'b0, atan_bam(step_q)});

	assign cos_v = to_q15(rx_q);
	assign sin_v = to_q15(ry_q);

	always_comb begin
		case (quad_q)
			2'd0: begin
				ue_d = sin_v;
				un_d = cos_v;
			end
			2'd1: begin
				ue_d = cos_v;
				un_d = -sin_v;
			end
			2'd2: begin
				ue_d = -sin_v;
				un_d = -cos_v;
			end
			default: begin
				ue_d = -cos_v;
				un_d = sin_v;
			end
		endcase
	end

	assign sw_ext = $signed({16'b0, sw_q});
	assign ue_ext = PROD_W'(ue_q);
	assign un_ext = PROD_W'(un_q);

	assign div_last = step_q == STEP_W'(SCALE_STEPS - 1);
	assign rot_last = step_q == STEP_W'(CORDIC_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_DIV && !div_last)
				step_q <= step_q + 1'b1;
			else if (state_q == F_ROT && !rot_last)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (item_valid) state_d = F_DIV;
			F_DIV:  if (div_last) state_d = F_ROT;
			F_ROT:  if (rot_last) state_d = F_MAP;
			F_MAP:  state_d = F_MUL;
			F_MUL:  state_d = F_PUSH;
			F_PUSH: if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	assign item_stall = state_q != F_IDLE;
	assign push = (state_q == F_PUSH) && !full;
	assign entry = '{east_prod: pe_q, north_prod: pn_q, weight: weight_q, last: last_q};

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (item_valid) begin
					deg_q <= dir_mod;
					sw_q <= {16'b0, item.speed} * {16'b0, item.weight};
					weight_q <= item.weight;
					last_q <= item.last;
				end
			end
			F_DIV: begin
				if (step_q == STEP_W'(0)) begin
					q0_q <= 32'((48'(deg_q) * 48'(RECIP_TURN)) >> 16);
				end else if (step_q == STEP_W'(1)) begin
					// only the low bits of the remainder survive; it is below three turns
					rm_q <= RND_BIAS[16:0] - 17'(q0_q * DEG_TURN);
				end else begin
					quad_q <= bam_fix[31:30];
					rx_q <= GAIN_INV;
					ry_q <= '0;
					rz_q <= $signed({3'b0, bam_fix[29:0]});
				end
			end
			F_ROT: begin
				if (!rz_q[32]) begin
					rx_q <= rx_q - rdx;
					ry_q <= ry_q + rdy;
					rz_q <= rz_q - atan_s;
				end else begin
					rx_q <= rx_q + rdx;
					ry_q <= ry_q - rdy;
					rz_q <= rz_q + atan_s;
				end
			end
			F_MAP: begin
				ue_q <= ue_d;
				un_q <= un_d;
			end
			F_MUL: begin
				pe_q <= sw_ext * ue_ext;
				pn_q <= sw_ext * un_ext;
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/wpvm_fifo.sv @@
// Short word queue between the front end and the accumulator.
`timescale 1ns / 1ps
`default_nettype none
module wpvm_fifo import wpvm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  wpvm_entry_t wdata,
	output logic        full,
	input  logic        pop,
	output wpvm_entry_t rdata,
	output logic        empty
);

	wpvm_entry_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_PTR_W:0] cnt_q;

	assign full = cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

@@ sv/wpvm_back.sv @@
// Back end: accumulate products, then divide, root and bearing on the last word.
`timescale 1ns / 1ps
`default_nettype none
module wpvm_back import wpvm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	output logic        pop,
	input  wpvm_entry_t entry,
	output logic        result_valid,
	input  logic        result_stall,
	output wpvm_out_t   result
);

	back_state_t state_q, state_d;
	logic [SEQ_W-1:0] step_q;
	logic part_q;
	logic wz_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [SUM_W-1:0] east_q, north_q;
	logic [WTOT_W-1:0] wtot_q;
	logic res_valid_q;
	wpvm_out_t res_q;

	logic [WTOT_W-1:0] rem_q;
	logic [SUM_W-1:0] dq_q;
	logic [MEAN_W-1:0] mag_e_q, mag_n_q;
	logic neg_e_q, neg_n_q;
	logic [2*MEAN_W-1:0] sq_e_q, sq_n_q;
	logic [RAD_W-1:0] v_q, r_q, bit_q;
	logic signed [VEC_W-1:0] vx_q, vy_q;
	logic [31:0] vz_q;
	logic [PROD_W-1:0] hprod_q;

	logic signed [SUM_W:0] east_add, north_add;
	logic signed [SUM_W-1:0] east_next, north_next;
	logic [WTOT_W:0] wtot_add;
	logic [WTOT_W:0] div_t, div_sub;
	logic div_ge;
	logic [SUM_W-1:0] quo_next;
	logic [MEAN_W-1:0] mean_sat;
	logic [RAD_W-1:0] root_try;
	logic root_ge;
	logic signed [VEC_W-1:0] e_s, n_s, vdx, vdy;
	logic [31:0] atan_v;
	logic vec_zero;
	logic [2*MEAN_W-1:0] me_ext, mn_ext;
	logic [PROD_W-1:0] z_ext;
	logic [PROD_W-1:0] h_sum;
	logic [15:0] h_raw, h_fin;
	logic [32:0] m_sum;
	logic [15:0] m_fin;
	logic div_last, root_last, vec_last, accum_ok, load;

	function automatic logic [SUM_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
		mag_of = v[SUM_W-1] ? SUM_W'(~v) + SUM_W'(1) : v;
	endfunction

	// saturating accumulate
	assign east_add = (SUM_W + 1)'(east_q) + (SUM_W + 1)'(entry.east_prod);
	assign north_add = (SUM_W + 1)'(north_q) + (SUM_W + 1)'(entry.north_prod);
	assign east_next = (east_add[SUM_W] != east_add[SUM_W-1]) ?
		(east_add[SUM_W] ? SUM_MIN : SUM_MAX) : east_add[SUM_W-1:0];
	assign north_next = (north_add[SUM_W] != north_add[SUM_W-1]) ?
		(north_add[SUM_W] ? SUM_MIN : SUM_MAX) : north_add[SUM_W-1:0];
	assign wtot_add = {1'b0, wtot_q} + (WTOT_W + 1)'(entry.weight);
	assign accum_ok = cnt_q < CNT_W'(MAX_ITEMS);

	// one quotient bit a cycle
	assign div_t = {rem_q, dq_q[SUM_W-1]};
	assign div_sub = div_t - {1'b0, wtot_q};
	assign div_ge = div_t >= {1'b0, wtot_q};
	assign quo_next = {dq_q[SUM_W-2:0], div_ge};
	assign mean_sat = (|quo_next[SUM_W-1:MEAN_W]) ? '1 : quo_next[MEAN_W-1:0];

	assign root_try = r_q + bit_q;
	assign root_ge = v_q >= root_try;

	assign e_s = neg_e_q ? -$signed({5'b0, mag_e_q}) : $signed({5'b0, mag_e_q});
	assign n_s = neg_n_q ? -$signed({5'b0, mag_n_q}) : $signed({5'b0, mag_n_q});
	assign vec_zero = (mag_e_q == '0) && (mag_n_q == '0);
	assign vdx = vy_q >>> step_q[STEP_W-1:0];
	assign vdy = vx_q >>> step_q[STEP_W-1:0];
	assign atan_v = atan_bam(step_q[STEP_W-1:0]);

	assign me_ext = {{MEAN_W{1'b0}}, mag_e_q};
	assign mn_ext = {{MEAN_W{1'b0}}, mag_n_q};
	assign z_ext = {16'b0, vz_q};

	assign h_sum = hprod_q + 48'h0000_8000_0000;
	assign h_raw = h_sum[47:32];
	assign h_fin = (h_raw >= DEG_TURN) ? 16'd0 : h_raw;
	assign m_sum = {1'b0, r_q[31:0]} + 33'd16384;
	assign m_fin = (|m_sum[32:31]) ? 16'hFFFF : m_sum[30:15];

	assign div_last = step_q == SEQ_W'(SUM_W - 1);
	assign root_last = step_q == SEQ_W'(ROOT_STEPS - 1);
	assign vec_last = step_q == SEQ_W'(CORDIC_STEPS - 1);

	assign pop = (state_q == B_ACC) && !empty;
	assign load = (state_q == B_FIN) && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_ACC:   if (!empty && entry.last) state_d = B_CHECK;
			B_CHECK: state_d = (wtot_q == '0) ? B_FIN : B_DIV;
			B_DIV:   if (div_last && part_q) state_d = B_SQR;
			B_SQR:   state_d = B_SUM;
			B_SUM:   state_d = B_ROOT;
			B_ROOT:  if (root_last) state_d = vec_zero ? B_SCALE : B_VEC;
			B_VEC:   if (vec_last) state_d = B_SCALE;
			B_SCALE: state_d = B_FIN;
			B_FIN:   if (load) state_d = B_ACC;
			default: state_d = B_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_ACC;
			step_q <= '0;
			part_q <= 1'b0;
			wz_q <= 1'b0;
			cnt_q <= '0;
			east_q <= '0;
			north_q <= '0;
			wtot_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				B_ACC: begin
					step_q <= '0;
					if (pop && accum_ok) begin
						east_q <= east_next;
						north_q <= north_next;
						wtot_q <= wtot_add[WTOT_W] ? '1 : wtot_add[WTOT_W-1:0];
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_CHECK: begin
					step_q <= '0;
					part_q <= 1'b0;
					wz_q <= wtot_q == '0;
				end
				B_DIV: begin
					if (div_last) begin
						step_q <= '0;
						part_q <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				B_ROOT, B_VEC: begin
					step_q <= (state_d == state_q) ? step_q + 1'b1 : '0;
				end
				B_FIN: begin
					step_q <= '0;
					if (load) begin
						east_q <= '0;
						north_q <= '0;
						wtot_q <= '0;
						cnt_q <= '0;
						wz_q <= 1'b0;
					end
				end
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_CHECK: begin
				rem_q <= '0;
				dq_q <= mag_of(east_q);
				neg_e_q <= east_q[SUM_W-1];
			end
			B_DIV: begin
				if (div_last && !part_q) begin
					mag_e_q <= mean_sat;
					rem_q <= '0;
					dq_q <= mag_of(north_q);
					neg_n_q <= north_q[SUM_W-1];
				end else begin
					rem_q <= div_ge ? div_sub[WTOT_W-1:0] : div_t[WTOT_W-1:0];
					dq_q <= quo_next;
					if (div_last)
						mag_n_q <= mean_sat;
				end
			end
			B_SQR: begin
				sq_e_q <= me_ext * me_ext;
				sq_n_q <= mn_ext * mn_ext;
			end
			B_SUM: begin
				v_q <= RAD_W'(sq_e_q) + RAD_W'(sq_n_q);
				r_q <= '0;
				bit_q <= RAD_W'(1) << (RAD_W - 2);
			end
			B_ROOT: begin
				if (root_ge) begin
					v_q <= v_q - root_try;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				// a zero vector never takes the negative branch, so its bearing starts at zero
				if (root_last) begin
					if (n_s < 0) begin
						vx_q <= -n_s;
						vy_q <= -e_s;
						vz_q <= 32'h8000_0000;
					end else begin
						vx_q <= n_s;
						vy_q <= e_s;
						vz_q <= '0;
					end
				end
			end
			B_VEC: begin
				if (vy_q > 0) begin
					vx_q <= vx_q + vdx;
					vy_q <= vy_q - vdy;
					vz_q <= vz_q + atan_v;
				end else begin
					vx_q <= vx_q - vdx;
					vy_q <= vy_q + vdy;
					vz_q <= vz_q - atan_v;
				end
			end
			B_SCALE: begin
				hprod_q <= z_ext * PROD_W'(DEG_TURN);
			end
			B_FIN: begin
				if (load) begin
					if (wz_q)
						res_q <= '{mean_speed: 16'd0, mean_direction: 16'd0, weight_zero: 1'b1};
					else
						res_q <= '{mean_speed: m_fin, mean_direction: h_fin, weight_zero: 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/weighted_polar_vector_mean.sv @@
// Top level of the weighted polar vector mean (wind vector averaging) block.
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+---------------------------------------------
//  item     | item_valid / item_stall     | speed, direction, weight, last
//  result   | result_valid / result_stall | mean_speed, mean_direction, weight_zero
//
// The front end takes one word at a time and stalls until it is queued: reciprocal angle scaling,
// rotation CORDIC, then map, multiply and queue push.
// After the last word of a set leaves the queue, the result follows:
// two 58-step divisions on one shared divider, a 32-step square root, a 30-step vectoring
// CORDIC and the bearing scale (a zero mean vector skips the vectoring, a zero weight total all of it).
// The front keeps taking words meanwhile until the queue fills.
// arst_n clears all sums, counters and handshake state; no clearing pass is needed.
// A stalled result holds in the output register while accumulation of the next set goes on.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_polar_vector_mean_defines.svh"
module weighted_polar_vector_mean import wpvm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  wpvm_in_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output wpvm_out_t result
);

	// queue between front and back
	logic q_push, q_full, q_pop, q_empty;
	wpvm_entry_t q_wdata, q_rdata;

	// classify the word: unit vector and weighted east/north products
	wpvm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (q_push),
		.entry      (q_wdata),
		.full       (q_full)
	);

	// decouple the two halves so each stalls on its own
	wpvm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// accumulate, and on the last word produce magnitude and bearing
	wpvm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (q_empty),
		.pop          (q_pop),
		.entry        (q_rdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// a set with a zero weight total must report a zeroed vector
	`WPVM_ASSERT_HOLDS(a_zero_result, clk, arst_n, result_valid && result.weight_zero, result.mean_speed == 16'd0 && result.mean_direction == 16'd0)
	// bearing always wraps into one turn
	`WPVM_ASSERT_HOLDS(a_dir_range, clk, arst_n, result_valid, result.mean_direction < DEG_TURN)
	// never push into a full queue
	`WPVM_ASSERT_HOLDS(a_no_overfill, clk, arst_n, q_push, !q_full)
	// front is busy right after it takes a word
	`WPVM_ASSERT_NEXT(a_front_busy, clk, arst_n, item_valid && !item_stall, item_stall)

endmodule
`default_nettype wire
